>>> rtl/gradient_edge_magnitude_3x3_macros.svh
// Assertion macros shared by the edge detector modules.
`ifndef GRADIENT_EDGE_MAGNITUDE_3X3_MACROS_SVH
`define GRADIENT_EDGE_MAGNITUDE_3X3_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define GEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication.
`define GEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

>>> rtl/gem_pkg.sv
// ----------------------------------------------------------------------------
// gem_pkg
// Shared types and constants of the gradient edge detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gem_pkg;

	localparam int DefMaxWidth = 1024;

	localparam logic [1:0] KERNEL_SOBEL   = 2'd0;
	localparam logic [1:0] KERNEL_PREWITT = 2'd1;
	localparam logic [1:0] KERNEL_SCHARR  = 2'd2;
	localparam logic [1:0] KERNEL_ROBERTS = 2'd3;

	localparam logic [1:0] REG_KERNEL = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [7:0] EDGE_MAX = 8'd255;

	// Work item handed from the window front to the root back end.
	typedef struct packed {
		logic [16:0] energy;   // gx*gx + gy*gy, saturated at 2^16
		logic [9:0]  column;
		logic [15:0] row;
	} gem_job_t;

endpackage

>>> rtl/gem_front.sv
// ----------------------------------------------------------------------------
// gem_front
// Keeps the line stores and window, counts raster position and forms the
// clamped gradient energy of each centre pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gradient_edge_magnitude_3x3_macros.svh"

module gem_front
	import gem_pkg::*;
#(
	parameter int MAX_WIDTH = DefMaxWidth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     kernel_mode,
	input  logic [10:0]    image_width,
	input  logic [15:0]    image_height,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     grey_in,
	input  logic           frame_start,
	output logic           job_valid,
	input  logic           job_ready,
	output gem_job_t       job
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = (AW > 10) ? AW : 10;
	localparam int WW = $clog2(MAX_WIDTH + 1);

	// Stage 1 holds a captured pixel while the line stores are read.
	logic              busy_q;
	logic [1:0]        phase_q;
	logic [7:0]        px_q;
	logic [CW-1:0]     col_q;
	logic [15:0]       row_q;
	logic [CW-1:0]     c_s1;
	logic [15:0]       r_s1;
	logic [7:0]        mem_up [MAX_WIDTH];
	logic [7:0]        mem_lo [MAX_WIDTH];
	logic [7:0]        up_s1, mid_s1;
	logic [7:0]        win_q [6];
	logic              pend_q;
	logic signed [12:0] gx_s2, gy_s2;
	logic              emit_s2;
	logic [CW-1:0]     c_s2;
	logic [15:0]       r_s2;
	logic [WW-1:0]     w_eff;
	logic [15:0]       h_eff;
	logic [CW-1:0]     c_now;
	logic [15:0]       r_now;
	logic              take;
	logic [WW-1:0]     fill_q;
	logic [AW-1:0]     addr;
	logic              vup_s1;
	logic [7:0]        up_v, mid_v;

	// Effective geometry.
	always_comb begin
		if ({5'd0, image_width} < 16'd2)
			w_eff = WW'(2);
		else if (32'(image_width) > 32'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(image_width);
		h_eff = (image_height < 16'd2) ? 16'd2 : image_height;
	end

	// Position of the incoming pixel, with start and mid-frame fixups.
	always_comb begin
		logic [CW-1:0] c;
		logic [15:0]   r;
		c = frame_start ? '0 : col_q;
		r = frame_start ? '0 : row_q;
		if (32'(c) >= 32'(w_eff)) begin
			c = '0;
			r = r + 16'd1;
		end
		if (r >= h_eff)
			r = '0;
		c_now = c;
		r_now = r;
	end

	assign in_ready = !busy_q;
	assign take     = in_valid && in_ready;

	// Three phases per pixel: read stores, compute, hand over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 2'd0;
			col_q   <= '0;
			row_q   <= '0;
			pend_q  <= 1'b0;
			emit_s2 <= 1'b0;
			c_s1    <= '0;
			r_s1    <= '0;
			px_q    <= '0;
			gx_s2   <= '0;
			gy_s2   <= '0;
			c_s2    <= '0;
			r_s2    <= '0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else begin
			if (take) begin
				busy_q  <= 1'b1;
				phase_q <= 2'd0;
				c_s1    <= c_now;
				r_s1    <= r_now;
				px_q    <= grey_in;
				if (32'(c_now) + 1 >= 32'(w_eff)) begin
					col_q <= '0;
					row_q <= (r_now + 16'd1 >= h_eff) ? 16'd0 : r_now + 16'd1;
				end else begin
					col_q <= c_now + CW'(1);
					row_q <= r_now;
				end
			end else if (busy_q && phase_q == 2'd0) begin
				phase_q <= 2'd1;
			end else if (busy_q && phase_q == 2'd1) begin
				// Gradients from window and fresh column.
				logic signed [12:0] a, b, p00, p10, p20, p01, p21, p02, p12, p22;
				a   = (kernel_mode == KERNEL_SCHARR) ? 13'sd3 : 13'sd1;
				b   = (kernel_mode == KERNEL_SOBEL) ? 13'sd2 :
				      (kernel_mode == KERNEL_PREWITT) ? 13'sd1 : 13'sd10;
				p00 = 13'({5'd0, win_q[0]}); p10 = 13'({5'd0, win_q[1]});
				p20 = 13'({5'd0, win_q[2]}); p01 = 13'({5'd0, win_q[3]});
				p21 = 13'({5'd0, win_q[5]}); p02 = 13'({5'd0, up_v});
				p12 = 13'({5'd0, mid_v});    p22 = 13'({5'd0, px_q});
				if (kernel_mode == KERNEL_ROBERTS) begin
					gx_s2   <= 13'({5'd0, win_q[4]}) - p22;
					gy_s2   <= p12 - p21;
					emit_s2 <= (r_s1 >= 16'd1) && (c_s1 >= CW'(1));
				end else begin
					gx_s2   <= a * (p02 - p00) + b * (p12 - p10) + a * (p22 - p20);
					gy_s2   <= a * (p20 - p00) + b * (p21 - p01) + a * (p22 - p02);
					emit_s2 <= (r_s1 >= 16'd2) && (c_s1 >= CW'(2));
				end
				c_s2 <= c_s1 - CW'(1);
				r_s2 <= r_s1 - 16'd1;
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= up_v;
				win_q[4] <= mid_v;
				win_q[5] <= px_q;
				phase_q  <= 2'd2;
				pend_q   <= 1'b0;
			end else if (busy_q && phase_q == 2'd2) begin
				if (!emit_s2) begin
					busy_q <= 1'b0;
				end else if (!pend_q) begin
					pend_q <= 1'b1;
				end else if (job_ready) begin
					busy_q <= 1'b0;
					pend_q <= 1'b0;
				end
			end
		end
	end

	// Line stores. Columns are always reached by counting up from zero, so the
	// entries written since reset form a prefix below the fill count.
	assign addr = c_s1[AW-1:0];
	always_ff @(posedge clk) begin
		if (busy_q && phase_q == 2'd0) begin
			up_s1  <= mem_up[addr];
			mid_s1 <= mem_lo[addr];
		end
		if (busy_q && phase_q == 2'd1) begin
			mem_up[addr] <= mid_v;
			mem_lo[addr] <= px_q;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			vup_s1 <= 1'b0;
		end else begin
			if (busy_q && phase_q == 2'd0) vup_s1 <= 32'(c_s1) < 32'(fill_q);
			if (busy_q && phase_q == 2'd1 && 32'(c_s1) == 32'(fill_q))
				fill_q <= fill_q + WW'(1);
		end
	end
	// An unwritten entry reads zero.
	assign up_v  = vup_s1 ? up_s1 : 8'd0;
	assign mid_v = vup_s1 ? mid_s1 : 8'd0;

	// Energy: sum of squares, saturated at 2^16.
	logic [25:0] e_s3;
	logic [12:0] ax, ay;
	assign ax = gx_s2[12] ? 13'(-gx_s2) : gx_s2;
	assign ay = gy_s2[12] ? 13'(-gy_s2) : gy_s2;
	always_ff @(posedge clk) begin
		if (busy_q && phase_q == 2'd2 && !pend_q)
			e_s3 <= ({13'd0, ax} * {13'd0, ax}) + ({13'd0, ay} * {13'd0, ay});
	end

	assign job_valid  = busy_q && phase_q == 2'd2 && pend_q;
	assign job.energy = (e_s3 >= 26'd65536) ? 17'h10000 : e_s3[16:0];
	assign job.column = c_s2[9:0];
	assign job.row    = r_s2;

	`GEM_ASSERT_IMP(a_job_phase, clk, arst_n, job_valid, busy_q)
	`GEM_ASSERT_NEXT(a_take_busy, clk, arst_n, take, busy_q)
	`GEM_ASSERT_IMP(a_no_take, clk, arst_n, busy_q, !in_ready)

endmodule

>>> rtl/gem_queue.sv
// ----------------------------------------------------------------------------
// gem_queue
// Two-entry queue between the gradient front and the root back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gradient_edge_magnitude_3x3_macros.svh"

module gem_queue
	import gem_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_ready,
	input  gem_job_t wr_data,
	output logic     rd_valid,
	input  logic     rd_ready,
	output gem_job_t rd_data
);

	gem_job_t   buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = buf_q[rp_q];

	// Pointer and count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= !wp_q;
			if (rd_valid && rd_ready) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
		end
	end

	always_ff @(posedge clk)
		if (wr_valid && wr_ready) buf_q[wp_q] <= wr_data;

	`GEM_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 2'd2)
	`GEM_ASSERT_IMP(a_ptr_eq, clk, arst_n, cnt_q == 2'd0 || cnt_q == 2'd2, wp_q == rp_q)

endmodule

>>> rtl/gem_root.sv
// ----------------------------------------------------------------------------
// gem_root
// Bit-serial floor square root of the energy, clamped to 255, with an
// output register toward the stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gradient_edge_magnitude_3x3_macros.svh"

module gem_root
	import gem_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  gem_job_t    job,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [7:0]  res_edge,
	output logic [9:0]  res_column,
	output logic [15:0] res_row
);

	logic        run_q;
	logic [3:0]  step_q;
	logic [16:0] v_q;
	logic [7:0]  r_q;

	assign job_ready = !run_q && !res_valid;

	// One result bit per cycle, most significant first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			res_valid  <= 1'b0;
			step_q     <= '0;
			v_q        <= '0;
			r_q        <= '0;
			res_column <= '0;
			res_row    <= '0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			if (job_valid && job_ready) begin
				run_q      <= 1'b1;
				step_q     <= 4'd8;
				v_q        <= job.energy;
				r_q        <= '0;
				res_column <= job.column;
				res_row    <= job.row;
			end else if (run_q) begin
				logic [7:0]  t;
				logic [15:0] sq;
				t  = r_q | (8'd1 << (step_q - 4'd1));
				sq = t * t;
				if (v_q[16])
					r_q <= EDGE_MAX;
				else if ({1'b0, sq} <= v_q)
					r_q <= t;
				step_q <= step_q - 4'd1;
				if (step_q == 4'd1) begin
					run_q     <= 1'b0;
					res_valid <= 1'b1;
				end
			end
		end
	end

	assign res_edge = r_q;

	`GEM_ASSERT_IMP(a_excl, clk, arst_n, run_q, !res_valid)
	`GEM_ASSERT_IMP(a_step, clk, arst_n, run_q, step_q != 4'd0)

endmodule

>>> rtl/gradient_edge_magnitude_3x3.sv
// Path from pixel request to result: the front's read, compute and hand-over phases,
// the queue, 8 square-root steps and the output register.
// Pacing: the front takes no new pixel until it is done with the last one; the
// bit-serial root takes no new job while one runs or waits, so dense results pace input.
// Reset (arst_n low, asynchronous) clears counters, window, line-store fill count
// and the queue; registers return to Sobel, 1024 x 1024.
// ----------------------------------------------------------------------------
// gradient_edge_magnitude_3x3
// Streaming Sobel/Prewitt/Scharr/Roberts edge magnitude on 8-bit grey pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gradient_edge_magnitude_3x3
	import gem_pkg::*;
#(
	parameter int MAX_WIDTH = DefMaxWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // grey level
	input  logic        s_axis_tuser,   // frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // edge_strength, out_column, out_row, zero fill
);

	logic [1:0]  kernel_q;
	logic [10:0] width_q;
	logic [15:0] height_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= KERNEL_SOBEL;
			width_q  <= 11'd1024;
			height_q <= 16'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KERNEL: kernel_q <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic     fj_valid, fj_ready, qj_valid, qj_ready;
	gem_job_t fj, qj;
	logic [7:0]  e;
	logic [9:0]  oc;
	logic [15:0] orow;

	gem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk, .arst_n,
		.kernel_mode(kernel_q), .image_width(width_q), .image_height(height_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.grey_in(s_axis_tdata), .frame_start(s_axis_tuser),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	gem_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
		.rd_valid(qj_valid), .rd_ready(qj_ready), .rd_data(qj)
	);

	gem_root u_root (
		.clk, .arst_n,
		.job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res_edge(e), .res_column(oc), .res_row(orow)
	);

	assign m_axis_tdata = {6'd0, orow, oc, e};

endmodule

>>> sim/tb_gradient_edge_magnitude_3x3.sv
// ----------------------------------------------------------------------------
// tb_gradient_edge_magnitude_3x3
// Self-checking bench for the streaming gradient edge magnitude block. A short
// table of directed pixels comes first. It is followed by random frames under
// every kernel and several image geometries. The bench keeps its own model of
// the line stores and the window, and checks every result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gradient_edge_magnitude_3x3;
	import gem_pkg::*;

	// Laid out like the low bits of m_axis_tdata: strength lowest.
	typedef struct packed {
		logic [15:0] row;
		logic [9:0]  column;
		logic [7:0]  strength;
	} edge_result_t;

	typedef struct {
		logic [7:0] pix;
		bit         fs;
		int         strength;   // -1 when left to the predictor
	} pixel_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_KERNEL;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;     // grey level
	logic        s_axis_tuser = 1'b0;   // frame_start
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;          // edge_strength, out_column, out_row, zero fill

	gradient_edge_magnitude_3x3 dut (.*);

	always #6 clk = ~clk;

	// Model state of the detector.
	logic [1:0]  kern_mode = KERNEL_SOBEL;
	logic [10:0] img_w = 11'd1024;
	logic [15:0] img_h = 16'd1024;
	logic [7:0]  upper_line [1024];
	logic [7:0]  lower_line [1024];
	logic [7:0]  win [6];
	int          col_cnt = 0;
	int          row_cnt = 0;

	edge_result_t expected_edges [$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          pixels_sent = 0;
	int          idle_mode = 0;
	bit          hold_go = 0;
	bit          hold_done = 0;

	function automatic logic [7:0] floor_root(int v);
		int r;
		int t;
		r = 0;
		if (v >= 65536)
			return EDGE_MAX;
		for (int b = 128; b != 0; b >>= 1) begin
			t = r | b;
			if (t * t <= v)
				r = t;
		end
		return r[7:0];
	endfunction

	// Advance the model by one pixel; hit is set when a result is due.
	function automatic void predict_edge(input logic [7:0] px, input bit fs,
			output bit hit, output edge_result_t res);
		int w, h, c, r, up, mid, gx, gy, a, b, p;
		w = img_w;
		h = img_h;
		if (w < 2) w = 2;
		if (w > 1024) w = 1024;
		if (h < 2) h = 2;
		hit = 0;
		res = '0;
		gx = 0;
		gy = 0;
		p = px;
		if (fs) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt = (row_cnt + 1) & 16'hFFFF;
		end
		if (row_cnt >= h)
			row_cnt = 0;
		c = col_cnt;
		r = row_cnt;
		up = upper_line[c];
		mid = lower_line[c];
		if (kern_mode == KERNEL_ROBERTS) begin
			if (r >= 1 && c >= 1) begin
				gx = int'(win[4]) - p;
				gy = mid - int'(win[5]);
				hit = 1;
			end
		end else if (r >= 2 && c >= 2) begin
			a = (kern_mode == KERNEL_SCHARR) ? 3 : 1;
			b = (kern_mode == KERNEL_SOBEL) ? 2 : (kern_mode == KERNEL_PREWITT) ? 1 : 10;
			gx = a * (up - int'(win[0])) + b * (mid - int'(win[1])) + a * (p - int'(win[2]));
			gy = a * (int'(win[2]) - int'(win[0])) + b * (int'(win[5]) - int'(win[3]))
				+ a * (p - up);
			hit = 1;
		end
		if (hit) begin
			res.strength = floor_root(gx * gx + gy * gy);
			res.column = 10'(c - 1);
			res.row = 16'(r - 1);
		end
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = up[7:0];
		win[4] = mid[7:0];
		win[5] = px;
		upper_line[c] = mid[7:0];
		lower_line[c] = px;
		col_cnt = c + 1;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt = r + 1;
			if (row_cnt >= h)
				row_cnt = 0;
		end
	endfunction

	// Register write, only issued while the block is idle.
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		wait (expected_edges.size() == 0);
		repeat (40) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_KERNEL: kern_mode = val[1:0];
			REG_WIDTH:  img_w = val[10:0];
			REG_HEIGHT: img_h = val;
			default: ;
		endcase
	endtask

	// Offer one pixel request and record what it should produce.
	task automatic send_pixel(logic [7:0] px, bit fs, int typed);
		bit hit;
		edge_result_t res;
		int idle_pct;
		idle_pct = (idle_mode == 0) ? 38 : (idle_mode == 1) ? 66 : 0;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = px;
		s_axis_tuser = fs;
		do @(posedge clk); while (!s_axis_tready);
		predict_edge(px, fs, hit, res);
		if (hit) begin
			if (typed >= 0)
				res.strength = typed[7:0];
			expected_edges.push_back(res);
		end
		pixels_sent++;
	endtask

	// Receiver: random stalls, plus one long hold-off to back the block up.
	initial begin
		int idle_pct;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				m_axis_tready = 1'b0;
				repeat (300) @(negedge clk);
				hold_done = 1;
			end
			idle_pct = (idle_mode == 0) ? 66 : (idle_mode == 1) ? 38 : 0;
			m_axis_tready = !($urandom_range(99) < idle_pct);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		edge_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[33:0];
			results_seen++;
			if (expected_edges.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: strength %0d column %0d row %0d",
						got.strength, got.column, got.row);
			end else begin
				want = expected_edges.pop_front();
				if (got !== want || m_axis_tdata[39:34] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
							want.strength, want.column, want.row,
							got.strength, got.column, got.row);
				end
			end
		end
	end

	// Watchdog.
	initial begin
		#40ms;
		$display("gradient_edge_magnitude_3x3 test failed");
		$finish;
	end

	// Directed pixels: two 3x3 frames with readable results, then a restart.
	pixel_row_t directed_rows [23] = '{
		'{8'd0, 1, -1}, '{8'd0, 0, -1}, '{8'd0, 0, -1},
		'{8'd0, 0, -1}, '{8'd0, 0, -1}, '{8'd0, 0, -1},
		'{8'd255, 0, -1}, '{8'd255, 0, -1}, '{8'd255, 0, 255},
		'{8'd255, 1, -1}, '{8'd255, 0, -1}, '{8'd255, 0, -1},
		'{8'd255, 0, -1}, '{8'd255, 0, -1}, '{8'd255, 0, -1},
		'{8'd255, 0, -1}, '{8'd255, 0, -1}, '{8'd255, 0, 0},
		'{8'd255, 1, -1}, '{8'd0, 0, -1}, '{8'd255, 0, -1},
		'{8'd0, 0, -1}, '{8'd255, 1, -1}
	};

	// Random phases: kernel, width and height writes, pixel count, idling.
	logic [1:0]  ph_kern [8] = '{KERNEL_SOBEL, KERNEL_PREWITT, KERNEL_ROBERTS,
		KERNEL_SCHARR, KERNEL_ROBERTS, KERNEL_PREWITT, KERNEL_SOBEL, KERNEL_SCHARR};
	logic [15:0] ph_w [8] = '{16'd0, 16'd5, 16'd2, 16'd7, 16'd9, 16'd1, 16'd2047, 16'd3};
	logic [15:0] ph_h [8] = '{16'd0, 16'd4, 16'd2, 16'd3, 16'd65535, 16'd2, 16'd3, 16'd65535};
	int          ph_n [8] = '{60, 180, 120, 180, 180, 100, 120, 160};
	int          ph_idle [8] = '{0, 0, 0, 1, 1, 1, 2, 2};

	// Stimulus.
	initial begin
		logic [7:0] px;
		foreach (upper_line[i]) begin
			upper_line[i] = '0;
			lower_line[i] = '0;
		end
		foreach (win[i])
			win[i] = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_WIDTH, 16'd3);
		write_reg(REG_HEIGHT, 16'd3);
		foreach (directed_rows[i])
			send_pixel(directed_rows[i].pix, directed_rows[i].fs, directed_rows[i].strength);

		for (int p = 0; p < 8; p++) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			write_reg(REG_KERNEL, ph_kern[p]);
			write_reg(REG_WIDTH, ph_w[p]);
			write_reg(REG_HEIGHT, ph_h[p]);
			idle_mode = ph_idle[p];
			if (p == 7)
				hold_go = 1;
			for (int i = 0; i < ph_n[p]; i++) begin
				case ($urandom_range(3))
					0: px = 8'd0;
					1: px = 8'd255;
					default: px = 8'($urandom);
				endcase
				send_pixel(px, $urandom_range(39) == 0, -1);
			end
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;

		wait (expected_edges.size() == 0);
		repeat (60) @(posedge clk);
		mismatches += expected_edges.size();
		$display("Sent %0d pixels over all four kernels and nine geometries; %0d results checked.",
			pixels_sent, results_seen);
		if (mismatches == 0)
			$display("gradient_edge_magnitude_3x3 test passed");
		else
			$display("gradient_edge_magnitude_3x3 test failed");
		$finish;
	end

endmodule
